>>> rtl/core/bct_pkg.sv
// shared types and constants for the box collision table
`timescale 1ns / 1ps
package bct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NEAREST_W = 6;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_ADD     = 2'd1,
      MODE_OVERLAP = 2'd2,
      MODE_LINE    = 2'd3
   } mode_type;

   // one stored box, edges precomputed at add time
   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [16:0] box_x;
      logic signed [17:0] box_x_end;
      logic signed [16:0] box_y;
      logic signed [17:0] box_y_end;
   } entry_type;

   // query as it travels down the chain
   typedef struct packed {
      mode_type           mode;
      logic signed [16:0] qx;
      logic signed [17:0] qx_end;
      logic signed [16:0] qy;
      logic signed [17:0] qy_end;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [17:0] lo;
      logic signed [17:0] hi;
      logic               dir_pos;
      logic               dir_neg;
   } query_type;

   // running answer handed from cell to cell
   typedef struct packed {
      logic               collides;
      logic               have;
      logic signed [15:0] best_x;
      logic [IDX_W-1:0]   best_idx;
      logic               overflow;
   } partial_type;

endpackage

>>> rtl/core/bct_cell.sv
// one table cell: holds a box and updates the passing query answer
`timescale 1ns / 1ps
module bct_cell
   import bct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             active,
   input  logic             wr_en,
   input  entry_type        wr_entry,
   input  logic             v_in,
   input  query_type        q_in,
   input  partial_type      p_in,
   output logic             v_out,
   output query_type        q_out,
   output partial_type      p_out
);

   entry_type   entry_ff;
   logic        v_ff;
   query_type   q_ff;
   partial_type p_ff;
   partial_type p_in_next;
   logic        hit_ovl;
   logic        line_ok;
   logic        take_right;
   logic        take_left;

   always_comb begin
      hit_ovl = active && (q_in.mode == MODE_OVERLAP) &&
                (q_in.qx <= entry_ff.box_x_end) && (q_in.qx_end >= entry_ff.box_x) &&
                (q_in.qy_end >= entry_ff.box_y) && (q_in.qy <= entry_ff.box_y_end);
      line_ok = active && (q_in.mode == MODE_LINE) &&
                (entry_ff.pos_x >= q_in.lo) && (entry_ff.pos_x <= q_in.hi) &&
                (q_in.py >= entry_ff.box_y) && (q_in.py <= entry_ff.box_y_end);
      // strict compare keeps the earlier entry on a tie
      take_right = q_in.dir_pos && (entry_ff.pos_x >= q_in.px) &&
                   (!p_in.have || (entry_ff.pos_x < p_in.best_x));
      take_left  = q_in.dir_neg && (entry_ff.pos_x <= q_in.px) &&
                   (!p_in.have || (entry_ff.pos_x > p_in.best_x));
      p_in_next = p_in;
      p_in_next.collides = p_in.collides | hit_ovl;
      if (line_ok && (take_right || take_left)) begin
         p_in_next.have     = 1'b1;
         p_in_next.best_x   = entry_ff.pos_x;
         p_in_next.best_idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
      q_ff <= q_in;
      p_ff <= p_in_next;
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign v_out = v_ff;
   assign q_out = q_ff;
   assign p_out = p_ff;

endmodule

>>> rtl/core/box_collision_table_top.sv
// box collision table: front stage, chain of entry cells and result register
`timescale 1ns / 1ps
// an item passes the front stage register, every cell register and the result register before rsp_tvalid
// a new item is taken only once the previous result has gone to the output register; the query walks one cell per cycle
// every mode, clear and add included, passes the full chain of cells
// a finished result waits in the output register while the next item is taken
// reset empties the table and clears all valid flags; stored boxes are not cleared
module box_collision_table_top
   import bct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, hit_x, hit_y, hit_w, hit_h, direction, reach
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // collides, found, nearest_index, overflow, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DRAIN
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        v0_ff, v0_in;
   query_type   q0_ff, q0_in;
   partial_type p0_ff, p0_in;
   partial_type res_ff, res_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [15:0] px, py, hx, hy, hx_box, hy_box;
   logic [14:0]        hw, hh;
   logic [1:0]         dir;
   logic [15:0]        maxd;
   mode_type           req_mode;
   logic               accept;
   logic               table_full;
   logic               add_go;
   entry_type          new_entry;
   logic               out_free;

   logic                     v_chain [0:TABLE_ENTRIES];
   query_type                q_chain [0:TABLE_ENTRIES];
   partial_type              p_chain [0:TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] active;
   logic [TABLE_ENTRIES-1:0] wr_en;
   logic [TABLE_ENTRIES-1:0] v_cells;

   assign px       = req_tdata[15:0];
   assign py       = req_tdata[31:16];
   assign hx       = req_tdata[47:32];
   assign hy       = req_tdata[63:48];
   assign hw       = req_tdata[78:64];
   assign hh       = req_tdata[93:79];
   assign dir      = req_tdata[95:94];
   assign maxd     = req_tdata[111:96];
   assign req_mode = mode_type'(req_tuser);
   assign hx_box   = hx;
   assign hy_box   = hy;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign table_full = (count_ff >= CNT_W'(TABLE_ENTRIES));
   assign add_go     = accept && (req_mode == MODE_ADD) && !table_full;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      new_entry.pos_x     = px;
      new_entry.box_x     = {px[15], px} + {hx_box[15], hx_box};
      new_entry.box_x_end = {new_entry.box_x[16], new_entry.box_x} + {3'b000, hw};
      new_entry.box_y     = {py[15], py} + {hy_box[15], hy_box};
      new_entry.box_y_end = {new_entry.box_y[16], new_entry.box_y} + {3'b000, hh};
   end

   always_comb begin
      q0_in.mode    = req_mode;
      q0_in.qx      = new_entry.box_x;
      q0_in.qx_end  = new_entry.box_x_end;
      q0_in.qy      = new_entry.box_y;
      q0_in.qy_end  = new_entry.box_y_end;
      q0_in.px      = px;
      q0_in.py      = py;
      q0_in.lo      = {{2{px[15]}}, px} - {2'b00, maxd};
      q0_in.hi      = {{2{px[15]}}, px} + {2'b00, maxd};
      q0_in.dir_pos = (dir == 2'b01);
      q0_in.dir_neg = dir[1];
      p0_in.collides = 1'b0;
      p0_in.have     = 1'b0;
      p0_in.best_x   = '0;
      p0_in.best_idx = '0;
      p0_in.overflow = (req_mode == MODE_ADD) && table_full;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      v0_in         = accept;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
               if (req_mode == MODE_CLEAR) begin
                  count_in = '0;
               end else if (add_go) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_BUSY: begin
            if (v_chain[TABLE_ENTRIES]) begin
               res_in   = p_chain[TABLE_ENTRIES];
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {(RSP_DATA_W - NEAREST_W - 3)'(0), res_ff.overflow,
                                NEAREST_W'(res_ff.have ? res_ff.best_idx : '0),
                                res_ff.have, res_ff.collides};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q0_ff       <= q0_in;
      p0_ff       <= p0_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         v0_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         v0_ff         <= v0_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign v_chain[0] = v0_ff;
   assign q_chain[0] = q0_ff;
   assign p_chain[0] = p0_ff;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      assign active[i]  = (count_ff > CNT_W'(i));
      assign wr_en[i]   = add_go && (count_ff == CNT_W'(i));
      assign v_cells[i] = v_chain[i + 1];
      bct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .active   (active[i]),
         .wr_en    (wr_en[i]),
         .wr_entry (new_entry),
         .v_in     (v_chain[i]),
         .q_in     (q_chain[i]),
         .p_in     (p_chain[i]),
         .v_out    (v_chain[i + 1]),
         .q_out    (q_chain[i + 1]),
         .p_out    (p_chain[i + 1])
      );
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // only one item is ever in the chain
   assert property (@(posedge clock) disable iff (reset)
      ($countones({v_cells, v0_ff}) <= 1))
      else $error("more than one item in the cell chain");

   // the chain only carries an item while the block is busy
   assert property (@(posedge clock) disable iff (reset)
      ((v0_ff || (v_cells != '0)) |-> (state_ff == ST_BUSY)))
      else $error("chain active outside busy state");

   // no new transfer is taken until the previous item finishes
   assert property (@(posedge clock) disable iff (reset)
      (accept |=> !req_tready))
      else $error("input taken while an item is in flight");

   // the table never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(TABLE_ENTRIES)))
      else $error("entry count above table size");

endmodule
